FILE: sv/http_header_field_parser_unit_defines.svh
// ---------------------------------------------------------------------------
// http header field parser - assertion macros
// shared property forms used by the port checker
// ---------------------------------------------------------------------------
`ifndef HTTP_HEADER_FIELD_PARSER_UNIT_DEFINES_SVH
`define HTTP_HEADER_FIELD_PARSER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HFP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hfp check failed: same-cycle property");

// consequent must hold in the cycle after the antecedent
`define HFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfp check failed: next-cycle property");

`endif

FILE: sv/hfp_pkg.sv
// ---------------------------------------------------------------------------
// hfp_pkg
// types, codes and constants of the http header field parser
// ---------------------------------------------------------------------------
package hfp_pkg;

    localparam int KEY_COUNT_BITS_DEF   = 8;
    localparam int VALUE_COUNT_BITS_DEF = 10;

    localparam int OFFSET_W = 10;
    localparam logic [OFFSET_W-1:0] MAX_OFFSET_RST = 10'd255;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_KEY    = 4'd1,
        ST_COLON  = 4'd2,
        ST_SPACE  = 4'd3,
        ST_VALUE  = 4'd4,
        ST_CR     = 4'd5,
        ST_LF     = 4'd6,
        ST_END_CR = 4'd7,
        ST_END_LF = 4'd8
    } hfp_state_t;

    typedef enum logic [2:0] {
        ROLE_SKIP     = 3'd0,
        ROLE_KEY      = 3'd1,
        ROLE_SEP      = 3'd2,
        ROLE_VALUE    = 3'd3,
        ROLE_LINE_END = 3'd4,
        ROLE_AFTER    = 3'd5,
        ROLE_ERROR    = 3'd6
    } hfp_role_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } hfp_req_t;

    typedef struct packed {
        logic [7:0] echo_byte;
        hfp_role_t  byte_role;
        logic       field_done;
        logic       headers_done;
        logic       parse_error;
        logic [7:0] key_length;
        logic [9:0] value_length;
    } hfp_res_t;

endpackage

FILE: sv/hfp_step.sv
// ---------------------------------------------------------------------------
// hfp_step
// per-byte line machine: next parser state, counters and result word
// ---------------------------------------------------------------------------
module hfp_step
    import hfp_pkg::*;
#(
    parameter int KEY_COUNT_BITS   = KEY_COUNT_BITS_DEF,
    parameter int VALUE_COUNT_BITS = VALUE_COUNT_BITS_DEF
)
(
    input  hfp_state_t                  state_cur,
    input  logic [KEY_COUNT_BITS-1:0]   key_cur,
    input  logic [VALUE_COUNT_BITS-1:0] val_cur,
    input  logic                        err_cur,
    input  hfp_req_t                    req,
    input  logic [OFFSET_W-1:0]         max_offset,
    output hfp_state_t                  state_nxt,
    output logic [KEY_COUNT_BITS-1:0]   key_nxt,
    output logic [VALUE_COUNT_BITS-1:0] val_nxt,
    output logic                        err_nxt,
    output hfp_res_t                    res
);

    localparam int CMP_W = (VALUE_COUNT_BITS > OFFSET_W) ? VALUE_COUNT_BITS : OFFSET_W;

    hfp_state_t                  st;
    logic [KEY_COUNT_BITS-1:0]   kc;
    logic [VALUE_COUNT_BITS-1:0] vc;
    logic                        ec;
    logic [7:0]                  b;
    logic                        is_crlf;
    logic                        val_over;
    hfp_role_t                   role;
    logic                        fdone;
    logic                        hdone;
    logic [7:0]                  key_len;
    logic [9:0]                  val_len;

    // restart clears the parser before this byte is handled
    always_comb
    begin
        st = req.restart ? ST_START : state_cur;
        kc = req.restart ? '0 : key_cur;
        vc = req.restart ? '0 : val_cur;
        ec = req.restart ? 1'b0 : err_cur;
    end

    assign b        = req.data_byte;
    assign is_crlf  = (b == CH_CR) || (b == CH_LF);
    assign val_over = (CMP_W'(vc) > CMP_W'(max_offset)) || (vc == '1);

    // next state
    always_comb
    begin
        state_nxt = st;
        key_nxt   = kc;
        val_nxt   = vc;
        err_nxt   = ec;
        if (!ec)
        begin
            unique case (st)
                ST_START:
                begin
                    if (!is_crlf)
                    begin
                        state_nxt = ST_KEY;
                        key_nxt   = KEY_COUNT_BITS'(1);
                        val_nxt   = '0;
                    end
                end
                ST_KEY:
                begin
                    if (b == CH_COLON)
                        state_nxt = ST_COLON;
                    else if (is_crlf)
                        err_nxt = 1'b1;
                    else if (kc != '1)
                        key_nxt = kc + 1'b1;
                end
                ST_COLON:
                begin
                    if (b == CH_SPACE)
                        state_nxt = ST_SPACE;
                    else
                        err_nxt = 1'b1;
                end
                ST_SPACE:
                begin
                    state_nxt = ST_VALUE;
                    val_nxt   = VALUE_COUNT_BITS'(1);
                end
                ST_VALUE:
                begin
                    if (b == CH_CR)
                        state_nxt = ST_CR;
                    else if (val_over)
                        err_nxt = 1'b1;
                    else
                        val_nxt = vc + 1'b1;
                end
                ST_CR:
                begin
                    if (b == CH_LF)
                        state_nxt = ST_LF;
                    else
                        err_nxt = 1'b1;
                end
                ST_LF:
                begin
                    if (b == CH_CR)
                        state_nxt = ST_END_CR;
                    else
                    begin
                        state_nxt = ST_KEY;
                        key_nxt   = KEY_COUNT_BITS'(1);
                        val_nxt   = '0;
                    end
                end
                ST_END_CR:
                begin
                    if (b == CH_LF)
                        state_nxt = ST_END_LF;
                    else
                        err_nxt = 1'b1;
                end
                ST_END_LF:
                begin
                    state_nxt = ST_END_LF;
                end
                default:
                begin
                    err_nxt = 1'b1;
                end
            endcase
        end
    end

    // byte role and completion flags
    always_comb
    begin
        role  = ROLE_ERROR;
        fdone = 1'b0;
        hdone = 1'b0;
        if (!err_nxt)
        begin
            unique case (st)
                ST_START:  role = is_crlf ? ROLE_SKIP : ROLE_KEY;
                ST_KEY:    role = (b == CH_COLON) ? ROLE_SEP : ROLE_KEY;
                ST_COLON:  role = ROLE_SEP;
                ST_SPACE:  role = ROLE_VALUE;
                ST_VALUE:  role = (b == CH_CR) ? ROLE_LINE_END : ROLE_VALUE;
                ST_CR:
                begin
                    role  = ROLE_LINE_END;
                    fdone = 1'b1;
                end
                ST_LF:     role = (b == CH_CR) ? ROLE_LINE_END : ROLE_KEY;
                ST_END_CR:
                begin
                    role  = ROLE_LINE_END;
                    hdone = 1'b1;
                end
                ST_END_LF: role = ROLE_AFTER;
                default:   role = ROLE_ERROR;
            endcase
        end
    end

    // saturate or extend counts to the result field widths
    generate
        if (KEY_COUNT_BITS > 8)
        begin : g_key_sat
            assign key_len = (|key_nxt[KEY_COUNT_BITS-1:8]) ? 8'hFF : key_nxt[7:0];
        end
        else
        begin : g_key_ext
            assign key_len = 8'(key_nxt);
        end
        if (VALUE_COUNT_BITS > 10)
        begin : g_val_sat
            assign val_len = (|val_nxt[VALUE_COUNT_BITS-1:10]) ? 10'h3FF : val_nxt[9:0];
        end
        else
        begin : g_val_ext
            assign val_len = 10'(val_nxt);
        end
    endgenerate

    always_comb
    begin
        res.echo_byte    = b;
        res.byte_role    = role;
        res.field_done   = fdone;
        res.headers_done = hdone;
        res.parse_error  = err_nxt;
        res.key_length   = key_len;
        res.value_length = val_len;
    end

endmodule

FILE: sv/http_header_field_parser_unit.sv
// ---------------------------------------------------------------------------
// http_header_field_parser_unit
// streaming parser for the header section of an http request
// results are registered to the output word, or to the skid word if stalled
// throughput: one byte per cycle unless stalled; combinational line machine
// a two-deep output stage lets a byte in while one result is stalled
// reset: parser in start state, counts and error cleared, limit 255
// ---------------------------------------------------------------------------
module http_header_field_parser_unit
    import hfp_pkg::*;
#(
    parameter int KEY_COUNT_BITS   = KEY_COUNT_BITS_DEF,
    parameter int VALUE_COUNT_BITS = VALUE_COUNT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  hfp_req_t            req_word,
    output logic                res_valid,
    input  logic                res_stall,
    output hfp_res_t            res_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [OFFSET_W-1:0] cfg_data
);

    hfp_state_t                  state_reg;
    hfp_state_t                  state_next;
    logic [KEY_COUNT_BITS-1:0]   key_reg;
    logic [KEY_COUNT_BITS-1:0]   key_next;
    logic [VALUE_COUNT_BITS-1:0] val_reg;
    logic [VALUE_COUNT_BITS-1:0] val_next;
    logic                        err_reg;
    logic                        err_next;
    logic [OFFSET_W-1:0]         max_off_reg;
    hfp_res_t                    step_res;

    hfp_res_t                    out_reg;
    hfp_res_t                    skid_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        skid_valid_reg;
    logic                        skid_valid_next;

    logic                        accept;
    logic                        pop;
    logic                        load_out_new;
    logic                        load_out_skid;
    logic                        load_skid;

    hfp_step #(
        .KEY_COUNT_BITS   (KEY_COUNT_BITS),
        .VALUE_COUNT_BITS (VALUE_COUNT_BITS)
    ) u_hfp_step (
        .state_cur  (state_reg),
        .key_cur    (key_reg),
        .val_cur    (val_reg),
        .err_cur    (err_reg),
        .req        (req_word),
        .max_offset (max_off_reg),
        .state_nxt  (state_next),
        .key_nxt    (key_next),
        .val_nxt    (val_next),
        .err_nxt    (err_next),
        .res        (step_res)
    );

    assign cfg_ready = 1'b1;

    // stall only while the skid word is occupied
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign pop       = out_valid_reg && !res_stall;

    assign load_out_new  = accept && (pop || !out_valid_reg);
    assign load_skid     = accept && out_valid_reg && !pop;
    assign load_out_skid = pop && skid_valid_reg;

    always_comb
    begin
        out_valid_next  = load_out_new || load_out_skid || (out_valid_reg && !pop);
        skid_valid_next = load_skid || (skid_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_START;
            key_reg        <= '0;
            val_reg        <= '0;
            err_reg        <= 1'b0;
            max_off_reg    <= MAX_OFFSET_RST;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                key_reg   <= key_next;
                val_reg   <= val_next;
                err_reg   <= err_next;
            end
            if (cfg_valid && cfg_ready)
                max_off_reg <= cfg_data;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_new)
            out_reg <= step_res;
        else if (load_out_skid)
            out_reg <= skid_reg;
        if (load_skid)
            skid_reg <= step_res;
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

endmodule

FILE: sv/hfp_checker.sv
// ---------------------------------------------------------------------------
// hfp_checker
// port-level checks of the http header field parser, bound to the top level
// ---------------------------------------------------------------------------
`include "http_header_field_parser_unit_defines.svh"

module hfp_checker
    import hfp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_stall,
    input logic     res_valid,
    input logic     res_stall,
    input hfp_res_t res_word
);

    // a held result word keeps its contents
    `HFP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))

    // input backpressure only while a result is pending at the output
    `HFP_ASSERT_SAME(a_stall_needs_res, req_stall, res_valid)

    // error state forces the error role and no completion flags
    `HFP_ASSERT_SAME(a_err_role, res_valid && res_word.parse_error,
        res_word.byte_role == ROLE_ERROR && !res_word.field_done && !res_word.headers_done)

    // error role only appears with the error flag
    `HFP_ASSERT_SAME(a_role_err, res_valid && res_word.byte_role == ROLE_ERROR,
        res_word.parse_error)

    // completion flags only on line-end bytes
    `HFP_ASSERT_SAME(a_done_line_end, res_valid && (res_word.field_done || res_word.headers_done),
        res_word.byte_role == ROLE_LINE_END && res_word.echo_byte == CH_LF)

endmodule

bind http_header_field_parser_unit hfp_checker u_hfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);
